FILE: sv/gradient_pixel_generator_assert.svh
// Assertion macros for the gradient pixel generator
`ifndef GRADIENT_PIXEL_GENERATOR_ASSERT_SVH
`define GRADIENT_PIXEL_GENERATOR_ASSERT_SVH

`define GPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define GPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/gpg_pkg.sv
// Shared types and constants of the gradient pixel generator
package gpg_pkg;

   localparam int CH_BITS     = 8;
   localparam int RGB_BITS    = 24;
   localparam int PEN_BITS    = 8;
   localparam int THR_BITS    = 5;
   localparam int Q_BITS      = 8;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = 2;
   localparam int STAGES      = DIV_STAGES + 3;

   typedef enum logic {
      CSR_HORIZONTAL = 1'b0,
      CSR_TRUECOLOR  = 1'b1
   } csr_index_type;

   typedef logic [STAGES-1:0] stage_en_type;

   localparam logic [THR_BITS-1:0] BAYER_TABLE [16] = '{
      5'd1,  5'd9,  5'd3,  5'd11,
      5'd13, 5'd5,  5'd15, 5'd7,
      5'd4,  5'd12, 5'd2,  5'd10,
      5'd16, 5'd8,  5'd14, 5'd6
   };

endpackage

FILE: sv/gpg_chan.sv
// One colour channel: multiply, rounding quotient two bits a stage, saturating add
module gpg_chan #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  gpg_pkg::stage_en_type         stage_en,
   input  logic [gpg_pkg::CH_BITS-1:0]   first_ch,
   input  logic [gpg_pkg::CH_BITS-1:0]   second_ch,
   input  logic [COORD_BITS-1:0]         pos,
   input  logic [COORD_BITS:0]           den,
   output logic [gpg_pkg::CH_BITS-1:0]   ch_out
);
   import gpg_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = COORD_BITS + CH_BITS + 2;
   localparam int NW = DW + Q_BITS;
   localparam int SW = CH_BITS + 2;

   logic signed [CH_BITS:0]  delta;
   logic signed [PW-1:0]     prod_in, prod_ff;
   logic [CH_BITS-1:0]       base1_ff;
   logic [DW-1:0]            den1_ff;

   logic signed [PW-1:0]     num;
   logic signed [PW-1:0]     mag_w;
   logic [NW-1:0]            mag_in;
   logic                     neg_in, ovf_in;

   logic [NW-1:0]            rem_ff  [0:DIV_STAGES];
   logic [Q_BITS-1:0]        quo_ff  [0:DIV_STAGES];
   logic [DW-1:0]            dend_ff [0:DIV_STAGES];
   logic                     neg_ff  [0:DIV_STAGES];
   logic                     ovf_ff  [0:DIV_STAGES];
   logic [CH_BITS-1:0]       base_ff [0:DIV_STAGES];

   logic [CH_BITS:0]         qmag;
   logic signed [SW-1:0]     qsig, sum;
   logic [CH_BITS-1:0]       out_in, out_ff;

   always_comb begin
      delta   = $signed({1'b0, second_ch}) - $signed({1'b0, first_ch});
      prod_in = PW'(delta) * PW'($signed({1'b0, pos}));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff  <= prod_in;
         base1_ff <= first_ch;
         den1_ff  <= den;
      end
   end

   always_comb begin
      num    = prod_ff + $signed({{(PW-DW+1){1'b0}}, den1_ff[DW-1:1]});
      neg_in = num[PW-1];
      mag_w  = neg_in ? -num : num;
      mag_in = mag_w[NW-1:0];
      ovf_in = mag_in >= {den1_ff, {Q_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rem_ff[0]  <= mag_in;
         quo_ff[0]  <= '0;
         dend_ff[0] <= den1_ff;
         neg_ff[0]  <= neg_in;
         ovf_ff[0]  <= ovf_in;
         base_ff[0] <= base1_ff;
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [NW-1:0]     rem_nx;
      logic [Q_BITS-1:0] quo_nx;
      logic [NW-1:0]     dsh;

      always_comb begin
         rem_nx = rem_ff[k];
         quo_nx = quo_ff[k];
         dsh    = '0;
         for (int j = 0; j < DIV_STEPS; j++) begin
            dsh = {{Q_BITS{1'b0}}, dend_ff[k]} << (Q_BITS - 1 - DIV_STEPS * k - j);
            if (rem_nx >= dsh) begin
               rem_nx = rem_nx - dsh;
               quo_nx = {quo_nx[Q_BITS-2:0], 1'b1};
            end else begin
               quo_nx = {quo_nx[Q_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k+2]) begin
            rem_ff[k+1]  <= rem_nx;
            quo_ff[k+1]  <= quo_nx;
            dend_ff[k+1] <= dend_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            base_ff[k+1] <= base_ff[k];
         end
      end
   end

   always_comb begin
      qmag = ovf_ff[DIV_STAGES] ? {1'b1, {CH_BITS{1'b0}}} : {1'b0, quo_ff[DIV_STAGES]};
      qsig = neg_ff[DIV_STAGES] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      sum  = $signed({2'b00, base_ff[DIV_STAGES]}) + qsig;
      if (sum[SW-1]) begin
         out_in = '0;
      end else if (sum[CH_BITS]) begin
         out_in = '1;
      end else begin
         out_in = sum[CH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign ch_out = out_ff;

endmodule

FILE: sv/gradient_pixel_generator.sv
// Top level of the gradient pixel generator
//
// Gives the pen or RGB colour of one pixel of a two-colour gradient segment. One word
// is taken every clock while req_stall is low, and each result passes through seven
// register stages: a multiplier stage, a rounding stage, four quotient stages that
// resolve two bits of the per-channel quotient each, and a saturating output stage. A
// stalled result holds only the last stage; words keep entering until every stage is
// full. Dither mode compares the scaled position with the 4x4 threshold by cross
// multiplication. The user must write the horizontal and truecolor_mode registers
// only while no word is in flight; the block itself does not enforce it.
`include "gradient_pixel_generator_assert.svh"

module gradient_pixel_generator #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_BITS-1:0]         req_col,
   input  logic [COORD_BITS-1:0]         req_row,
   input  logic [COORD_BITS:0]           req_span_length,
   input  logic [gpg_pkg::PEN_BITS-1:0]  req_first_pen,
   input  logic [gpg_pkg::PEN_BITS-1:0]  req_second_pen,
   input  logic [gpg_pkg::RGB_BITS-1:0]  req_first_rgb,
   input  logic [gpg_pkg::RGB_BITS-1:0]  req_second_rgb,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_rgb,
   output logic [gpg_pkg::PEN_BITS-1:0]  rsp_out_pen,
   output logic [gpg_pkg::RGB_BITS-1:0]  rsp_out_rgb,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  gpg_pkg::csr_index_type        csr_index,
   input  logic                          csr_wdata
);
   import gpg_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int NUM_W = COORD_BITS + 5;
   localparam int THR_W = DW + THR_BITS;
   localparam logic [DW-1:0] SHORT_MAX = DW'(2);
   localparam logic [DW-1:0] ONE = DW'(1);

   logic horizontal_ff, horizontal_in;
   logic truecolor_ff, truecolor_in;

   logic [STAGES-1:0] vld_ff, vld_in;
   stage_en_type      stage_en;

   logic [COORD_BITS-1:0] pos_sel;
   logic [DW-1:0]         den;
   logic [THR_BITS-1:0]   thr_sel;
   logic [NUM_W-1:0]      num_in, num_ff;
   logic [THR_W-1:0]      thr_in, thr_ff;
   logic                  short_in, short_ff;
   logic                  pos_zero_ff;
   logic                  tc1_ff;
   logic [PEN_BITS-1:0]   pen1_ff, pen2_ff;

   logic [PEN_BITS-1:0]   pen_in;
   logic                  rgb_sel_in;
   logic [PEN_BITS-1:0]   pen_ff     [1:STAGES-1];
   logic                  rgb_sel_ff [1:STAGES-1];

   logic [CH_BITS-1:0]    red_out, green_out, blue_out;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      horizontal_in = horizontal_ff;
      truecolor_in  = truecolor_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HORIZONTAL: horizontal_in = csr_wdata;
            CSR_TRUECOLOR:  truecolor_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizontal_ff <= 1'b0;
         truecolor_ff  <= 1'b0;
      end else begin
         horizontal_ff <= horizontal_in;
         truecolor_ff  <= truecolor_in;
      end
   end

   // stage enables: advance into a stage that is empty or draining
   assign stage_en[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
   for (genvar i = 0; i < STAGES - 1; i++) begin : g_en
      assign stage_en[i] = !vld_ff[i] || stage_en[i+1];
   end

   assign vld_in[0] = stage_en[0] ? req_valid : vld_ff[0];
   for (genvar i = 1; i < STAGES; i++) begin : g_vld
      assign vld_in[i] = stage_en[i] ? vld_ff[i-1] : vld_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // stage one: position, threshold products
   always_comb begin
      pos_sel  = horizontal_ff ? req_col : req_row;
      den      = req_span_length - ONE;
      short_in = req_span_length <= SHORT_MAX;
      thr_sel  = BAYER_TABLE[{req_row[1:0], req_col[1:0]}];
      num_in   = {1'b0, pos_sel, 4'b0000} + {5'b00000, den[DW-1:1]};
      thr_in   = {{DW{1'b0}}, thr_sel} * {{THR_BITS{1'b0}}, den};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         num_ff      <= num_in;
         thr_ff      <= thr_in;
         short_ff    <= short_in;
         pos_zero_ff <= pos_sel == '0;
         tc1_ff      <= truecolor_ff;
         pen1_ff     <= req_first_pen;
         pen2_ff     <= req_second_pen;
      end
   end

   // stage two: choose the pen
   always_comb begin
      rgb_sel_in = tc1_ff && !short_ff;
      if (short_ff) begin
         pen_in = pos_zero_ff ? pen1_ff : pen2_ff;
      end else if (tc1_ff) begin
         pen_in = '0;
      end else begin
         pen_in = ({1'b0, num_ff} < thr_ff) ? pen1_ff : pen2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         pen_ff[1]     <= pen_in;
         rgb_sel_ff[1] <= rgb_sel_in;
      end
   end

   for (genvar i = 2; i < STAGES; i++) begin : g_carry
      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            pen_ff[i]     <= pen_ff[i-1];
            rgb_sel_ff[i] <= rgb_sel_ff[i-1];
         end
      end
   end

   // colour channels
   gpg_chan #(.COORD_BITS(COORD_BITS)) u_red (
      .clock     (clock),
      .stage_en  (stage_en),
      .first_ch  (req_first_rgb[3*CH_BITS-1:2*CH_BITS]),
      .second_ch (req_second_rgb[3*CH_BITS-1:2*CH_BITS]),
      .pos       (pos_sel),
      .den       (den),
      .ch_out    (red_out)
   );

   gpg_chan #(.COORD_BITS(COORD_BITS)) u_green (
      .clock     (clock),
      .stage_en  (stage_en),
      .first_ch  (req_first_rgb[2*CH_BITS-1:CH_BITS]),
      .second_ch (req_second_rgb[2*CH_BITS-1:CH_BITS]),
      .pos       (pos_sel),
      .den       (den),
      .ch_out    (green_out)
   );

   gpg_chan #(.COORD_BITS(COORD_BITS)) u_blue (
      .clock     (clock),
      .stage_en  (stage_en),
      .first_ch  (req_first_rgb[CH_BITS-1:0]),
      .second_ch (req_second_rgb[CH_BITS-1:0]),
      .pos       (pos_sel),
      .den       (den),
      .ch_out    (blue_out)
   );

   assign rsp_is_rgb  = rgb_sel_ff[STAGES-1];
   assign rsp_out_pen = pen_ff[STAGES-1];
   assign rsp_out_rgb = rgb_sel_ff[STAGES-1] ? {red_out, green_out, blue_out} : '0;

   `GPG_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall, &vld_ff, "input held back while a stage is free")
   `GPG_ASSERT_NOW(a_free_output_no_stall, clock, reset, !rsp_stall, !req_stall, "input held back with output free")
   `GPG_ASSERT_NOW(a_rgb_needs_truecolor, clock, reset, rsp_valid && rsp_is_rgb, truecolor_ff, "rgb word outside truecolor mode")

endmodule
